/* hw/rtl/mpcf_pkg.sv */
// Package for the masked popcount constraint filter: sizes, codes, entry type, popcount.
`timescale 1ns / 1ps
package mpcf_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int EDGE_BITS   = 64;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int LIMIT_W     = 7;
  localparam int FIELD_W     = 64;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_CHECK  = 2'd2;

  localparam logic KIND_UPPER = 1'b0;
  localparam logic KIND_LOWER = 1'b1;

  localparam logic [1:0] VERDICT_PASS  = 2'd0;
  localparam logic [1:0] VERDICT_UPPER = 2'd1;
  localparam logic [1:0] VERDICT_LOWER = 2'd2;

  typedef struct packed {
    logic                 kind;
    logic [LIMIT_W-1:0]   limit;
    logic [EDGE_BITS-1:0] mask;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [6:0] popcount64(input logic [FIELD_W-1:0] v);
    logic [6:0] s [FIELD_W];
    for (int j = 0; j < FIELD_W; j++) s[j] = 7'(v[j]);
    for (int l = 0; l < 6; l++) begin
      for (int j = 0; j < (FIELD_W >> (l + 1)); j++) s[j] = s[2*j] + s[2*j+1];
    end
    return s[0];
  endfunction

endpackage

/* hw/rtl/mpcf_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module mpcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/masked_popcount_constraint_filter_top.sv */
// Top level of the masked popcount constraint filter: sequencer, table RAM and result register.
//
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_ready    | op, constraint_mask/kind/limit, graph_edges
//   out_    | output    | out_valid / out_ready  | verdict, table_overflow
//
// Clear and append give no item on out_.
// A check stops at the first entry that fails and otherwise reads the whole table,
// one table entry per cycle through the RAM read, popcount and compare stages.
// Reset clears the entry count, overflow flag and all control; the table needs no clearing.
// in_ready is low while a check runs and while its verdict waits for the result register.
`timescale 1ns / 1ps
module masked_popcount_constraint_filter_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_op,
  input  logic [mpcf_pkg::FIELD_W-1:0]   in_constraint_mask,
  input  logic                           in_constraint_kind,
  input  logic [mpcf_pkg::LIMIT_W-1:0]   in_constraint_limit,
  input  logic [mpcf_pkg::FIELD_W-1:0]   in_graph_edges,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_verdict,
  output logic                           out_table_overflow
);

  import mpcf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [CNT_W-1:0]     rd_addr_r, rd_addr_nxt;
  logic                 p1_vld_r, p1_vld_nxt;
  logic                 p2_vld_r, p2_vld_nxt;
  logic [6:0]           cnt_r, cnt_nxt;
  logic                 kind_r, kind_nxt;
  logic [LIMIT_W-1:0]   lim_r, lim_nxt;
  logic [EDGE_BITS-1:0] graph_r, graph_nxt;
  logic [1:0]           verdict_r, verdict_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_verdict_r, out_verdict_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  logic                 in_fire;
  logic                 issue;
  logic                 fail;
  logic                 wr_en;
  entry_t               wr_entry;
  entry_t               rd_entry;
  logic [ENTRY_W-1:0]   rd_data;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign issue    = (state_r == ST_CHECK) && (rd_addr_r < count_r);
  assign wr_en    = in_fire && (in_op == OP_APPEND) && (count_r < CNT_W'(TABLE_DEPTH));
  assign rd_entry = entry_t'(rd_data);

  assign wr_entry.kind  = in_constraint_kind;
  assign wr_entry.limit = in_constraint_limit;
  assign wr_entry.mask  = in_constraint_mask[EDGE_BITS-1:0];

  assign fail = (kind_r == KIND_LOWER) ? (cnt_r <= lim_r) : (cnt_r >= lim_r);

  mpcf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (issue),
    .rd_addr (rd_addr_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    ovf_nxt         = ovf_r;
    rd_addr_nxt     = rd_addr_r;
    p1_vld_nxt      = 1'b0;
    p2_vld_nxt      = 1'b0;
    cnt_nxt         = cnt_r;
    kind_nxt        = kind_r;
    lim_nxt         = lim_r;
    graph_nxt       = graph_r;
    verdict_nxt     = verdict_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_verdict_nxt = out_verdict_r;
    out_ovf_nxt     = out_ovf_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_CLEAR: begin
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            OP_APPEND: begin
              if (wr_en) begin
                count_nxt = count_r + CNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_CHECK: begin
              graph_nxt   = in_graph_edges[EDGE_BITS-1:0];
              rd_addr_nxt = '0;
              state_nxt   = ST_CHECK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (issue) begin
          rd_addr_nxt = rd_addr_r + CNT_W'(1);
        end
        p1_vld_nxt = issue;
        p2_vld_nxt = p1_vld_r;
        if (p1_vld_r) begin
          cnt_nxt  = popcount64(FIELD_W'(rd_entry.mask & graph_r));
          kind_nxt = rd_entry.kind;
          lim_nxt  = rd_entry.limit;
        end
        if (p2_vld_r && fail) begin
          verdict_nxt = (kind_r == KIND_LOWER) ? VERDICT_LOWER : VERDICT_UPPER;
          p1_vld_nxt  = 1'b0;
          p2_vld_nxt  = 1'b0;
          state_nxt   = ST_EMIT;
        end else if (!issue && !p1_vld_r && !p2_vld_r) begin
          verdict_nxt = VERDICT_PASS;
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = verdict_r;
          out_ovf_nxt     = ovf_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      p1_vld_r    <= p1_vld_nxt;
      p2_vld_r    <= p2_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r     <= rd_addr_nxt;
    cnt_r         <= cnt_nxt;
    kind_r        <= kind_nxt;
    lim_r         <= lim_nxt;
    graph_r       <= graph_nxt;
    verdict_r     <= verdict_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_ovf_r     <= out_ovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_verdict        = out_verdict_r;
  assign out_table_overflow = out_ovf_r;

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_issue_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> (rd_addr_r <= count_r))
    else $error("read address ran past entry count");

  a_check_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_op == OP_CHECK) |=> (!in_ready && !out_valid_nxt) || !in_ready)
    else $error("input taken while a check runs");

  a_pipe_empty_outside_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CHECK) |-> (!p1_vld_r && !p2_vld_r))
    else $error("table read stages busy outside a check");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (verdict_r == VERDICT_PASS || verdict_r == VERDICT_UPPER ||
                              verdict_r == VERDICT_LOWER))
    else $error("bad verdict code");

endmodule
